[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/core/dwct_pkg.sv]
// ---------------------------------------------------------------------------
// dwct_pkg
// Types and fixed constants of the digit window coverage tracker.
// ---------------------------------------------------------------------------
package dwct_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_RADIX          = 3'd0;
  localparam logic [2:0] CFG_WINDOW_LEN     = 3'd1;
  localparam logic [2:0] CFG_WINDOW_MODULUS = 3'd2;
  localparam logic [2:0] CFG_TOTAL_TARGET   = 3'd3;

  // Reset values of the configuration registers
  localparam logic [4:0]  RADIX_RESET      = 5'd10;
  localparam logic [4:0]  WINDOW_LEN_RESET = 5'd6;
  localparam logic [23:0] MODULUS_RESET    = 24'd100000;
  localparam logic [24:0] TOTAL_RESET      = 25'd1000000;

  localparam logic [4:0]  FILL_MAX  = 5'd31;
  localparam logic [4:0]  DIV_STEPS = 5'd24;
  localparam logic [24:0] SEEN_MAX  = 25'h1FF_FFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_MUL,
    ST_READ,
    ST_CHECK,
    ST_OUT
  } state_t;

endpackage

[rtl/core/dwct_ram.sv]
// ---------------------------------------------------------------------------
// dwct_ram
// Single-port synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
module dwct_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/digit_window_coverage_tracker.sv]
// ---------------------------------------------------------------------------
// digit_window_coverage_tracker
// Sliding digit window with a presence bitmap over all window values.
// ---------------------------------------------------------------------------
// Usage:
//   Digits enter on the s_ channel, one per item (s_tdata[3:0]). Each item
//   gives exactly one result item on the m_ channel: the current window, a
//   first-appearance flag, the distinct count, all-found, the digit position
//   and the record of the latest first appearance.
//   Configuration is to be written through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.
// Sequence:
//   One item at a time. Window update runs an accept step, the restoring
//   divider (window mod window_modulus: 24 steps and a finishing step) and
//   a multiply step, which also splits the new window into bitmap word and
//   bit. A full window within the bitmap then takes a bitmap read and a
//   check/write step; the output register is loaded after that, or straight
//   after the multiply for a window that is not full or lies beyond the
//   bitmap. The bit-serial divider takes most of the time per item.
// Reset:
//   rst clears all counters and records, then a clearing pass writes zero
//   to every bitmap word, one per cycle; no item is taken before it ends.
// Stall:
//   A result waits in the output register while m_tready is low; the next
//   item is still accepted and worked on, and only its final hand-over waits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module digit_window_coverage_tracker #(
  parameter int WORD_BITS     = 64,
  parameter int BITMAP_WORDS  = 262144,
  parameter int POSITION_BITS = 48
) (
  input  logic         clk,
  input  logic         rst,
  // input digits
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [3:0] digit, [7:4] zero
  // results
  output logic         m_tvalid,
  input  logic         m_tready,
  // [0] window_full, [24:1] window_value, [25] first_time,
  // [50:26] distinct_count, [51] all_found, [99:52] digit_position,
  // [147:100] last_new_position, [171:148] last_new_value, [175:172] zero
  output logic [175:0] m_tdata,
  // configuration
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [24:0]  cfg_data
);

  localparam int ADDR_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam logic [ADDR_W-1:0]        LAST_ADDR = ADDR_W'(BITMAP_WORDS - 1);
  localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;

  // configuration registers
  logic [4:0]  radix;
  logic [4:0]  window_len;
  logic [23:0] window_modulus;
  logic [24:0] total_target;

  // state
  dwct_pkg::state_t state, state_next;
  logic [ADDR_W-1:0]        clr_addr;
  logic [23:0]              window_reg;
  logic [4:0]               fill_count;
  logic [24:0]              seen_count;
  logic [POSITION_BITS-1:0] position_counter;
  logic [POSITION_BITS-1:0] latest_position;
  logic [23:0]              latest_value;
  logic [3:0]               digit_reg;
  logic                     cur_full;
  logic                     cur_first;
  logic [ADDR_W-1:0]        word_addr;

  // restoring divider for the modulus
  logic [23:0] div_rem;
  logic [23:0] div_quo;
  logic [23:0] div_den;
  logic [4:0]  div_cnt;
  logic [24:0] div_trial;
  logic        div_ge;
  logic        div_done;

  // output register
  logic                     out_full;
  logic [23:0]              out_window;
  logic                     out_first;
  logic [24:0]              out_count;
  logic                     out_all;
  logic [47:0]              out_pos;
  logic [47:0]              out_last_pos;
  logic [23:0]              out_last_val;
  logic                     out_load;

  // bitmap RAM
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_rdata;
  logic [BIT_W-1:0]     bit_idx;
  logic                 bit_hit;

  // window arithmetic
  logic [28:0] win_prod;
  logic [23:0] win_next;
  logic [23:0] win_word;
  logic [4:0]  fill_inc;
  logic        full_next;
  logic        in_range;
  logic [63:0] pos_ext;
  logic [63:0] latest_ext;

  dwct_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BITMAP_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // one restoring step: shift in next dividend bit, subtract if it fits
  assign div_trial = {div_rem, div_quo[23]};
  assign div_ge    = div_trial >= {1'b0, div_den};
  assign div_done  = (div_cnt == 5'd0);

  // remainder times radix plus digit, wrapped to 24 bits
  assign win_prod  = 29'(div_rem) * 29'(radix) + 29'(digit_reg);
  assign win_next  = win_prod[23:0];
  assign fill_inc  = (fill_count < dwct_pkg::FILL_MAX) ? fill_count + 5'd1 : fill_count;
  assign full_next = fill_inc >= window_len;

  // upper window bits pick the bitmap word, lower bits the bit within it
  assign win_word = win_next >> BIT_W;
  assign in_range = 25'(win_word) < 25'(BITMAP_WORDS);
  assign bit_idx  = window_reg[BIT_W-1:0];
  assign bit_hit  = mem_rdata[bit_idx];

  assign out_load = (state == dwct_pkg::ST_OUT) && (!m_tvalid || m_tready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dwct_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) state_next = dwct_pkg::ST_IDLE;
      end
      dwct_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = dwct_pkg::ST_MOD;
      end
      dwct_pkg::ST_MOD: begin
        if (div_done) state_next = dwct_pkg::ST_MUL;
      end
      dwct_pkg::ST_MUL: begin
        state_next = (full_next && in_range) ? dwct_pkg::ST_READ : dwct_pkg::ST_OUT;
      end
      dwct_pkg::ST_READ:  state_next = dwct_pkg::ST_CHECK;
      dwct_pkg::ST_CHECK: state_next = dwct_pkg::ST_OUT;
      dwct_pkg::ST_OUT: begin
        if (out_load) state_next = dwct_pkg::ST_IDLE;
      end
      default: state_next = dwct_pkg::ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = word_addr;
    mem_wdata = mem_rdata | (WORD_BITS'(1) << bit_idx);
    case (state)
      dwct_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      dwct_pkg::ST_IDLE:  s_tready = 1'b1;
      dwct_pkg::ST_CHECK: mem_we = !bit_hit;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dwct_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      radix          <= dwct_pkg::RADIX_RESET;
      window_len     <= dwct_pkg::WINDOW_LEN_RESET;
      window_modulus <= dwct_pkg::MODULUS_RESET;
      total_target   <= dwct_pkg::TOTAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dwct_pkg::CFG_RADIX:          radix          <= cfg_data[4:0];
        dwct_pkg::CFG_WINDOW_LEN:     window_len     <= cfg_data[4:0];
        dwct_pkg::CFG_WINDOW_MODULUS: window_modulus <= cfg_data[23:0];
        dwct_pkg::CFG_TOTAL_TARGET:   total_target   <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr         <= '0;
      window_reg       <= '0;
      fill_count       <= '0;
      seen_count       <= '0;
      position_counter <= '0;
      latest_position  <= '0;
      latest_value     <= '0;
      div_cnt          <= '0;
    end else begin
      case (state)
        dwct_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
        end
        dwct_pkg::ST_IDLE: begin
          // start window mod modulus; a zero modulus acts as one
          if (s_tvalid) begin
            digit_reg <= s_tdata[3:0];
            div_quo   <= window_reg;
            div_rem   <= '0;
            div_den   <= (window_modulus == 24'd0) ? 24'd1 : window_modulus;
            div_cnt   <= dwct_pkg::DIV_STEPS;
          end
        end
        dwct_pkg::ST_MOD: begin
          if (!div_done) begin
            div_rem <= div_ge ? 24'(div_trial - {1'b0, div_den}) : div_trial[23:0];
            div_quo <= {div_quo[22:0], div_ge};
            div_cnt <= div_cnt - 5'd1;
          end
        end
        dwct_pkg::ST_MUL: begin
          window_reg <= win_next;
          fill_count <= fill_inc;
          cur_full   <= full_next;
          cur_first  <= 1'b0;
          word_addr  <= win_word[ADDR_W-1:0];
          if (position_counter != POS_MAX) begin
            position_counter <= position_counter + POSITION_BITS'(1);
          end
        end
        dwct_pkg::ST_CHECK: begin
          if (!bit_hit) begin
            cur_first       <= 1'b1;
            latest_position <= position_counter;
            latest_value    <= window_reg;
            if (seen_count != dwct_pkg::SEEN_MAX) seen_count <= seen_count + 25'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign pos_ext    = 64'(position_counter);
  assign latest_ext = 64'(latest_position);

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_full     <= cur_full;
      out_window   <= window_reg;
      out_first    <= cur_first;
      out_count    <= seen_count;
      out_all      <= (seen_count == total_target);
      out_pos      <= pos_ext[47:0];
      out_last_pos <= latest_ext[47:0];
      out_last_val <= latest_value;
    end
  end

  assign m_tdata = {4'b0000, out_last_val, out_last_pos, out_pos, out_all,
                    out_count, out_first, out_window, out_full};

  // distinct count never falls
  `ASSERT_NEXT(a_seen_monotonic, clk, rst, 1'b1, seen_count >= $past(seen_count))
  // bitmap written only by the clearing pass or a first appearance
  `ASSERT_IMPLIES(a_mem_write_src, clk, rst, mem_we,
                  (state == dwct_pkg::ST_CLEAR) || (state == dwct_pkg::ST_CHECK))
  // a first appearance needs a full window
  `ASSERT_IMPLIES(a_first_needs_full, clk, rst, m_tvalid && out_first, out_full)

endmodule
